// File: rtl/tpba_pkg.sv
`default_nettype none

package tpba_pkg;

    localparam int SMALL_BLOCKS = 32;
    localparam int BIG_BLOCKS   = 16;

    localparam int SMALL_IDX_W = (SMALL_BLOCKS > 1) ? $clog2(SMALL_BLOCKS) : 1;
    localparam int BIG_IDX_W   = (BIG_BLOCKS > 1) ? $clog2(BIG_BLOCKS) : 1;
    localparam int SMALL_CNT_W = $clog2(SMALL_BLOCKS + 1);
    localparam int BIG_CNT_W   = $clog2(BIG_BLOCKS + 1);

    localparam int SIZE_W      = 16;
    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int SMALL_USE_W = 6;
    localparam int BIG_USE_W   = 5;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [SIZE_W-1:0] RST_SMALL_LIMIT = 16'd64;
    localparam logic [SIZE_W-1:0] RST_BIG_LIMIT   = 16'd1024;
    localparam logic [ADDR_W-1:0] RST_SMALL_BASE  = 32'd0;
    localparam logic [ADDR_W-1:0] RST_BIG_BASE    = 32'd256;

    typedef enum logic [STATUS_W-1:0] {
        ST_SMALL_GRANT = 3'd0,
        ST_BIG_GRANT   = 3'd1,
        ST_HEAP        = 3'd2,
        ST_SMALL_FREE  = 3'd3,
        ST_BIG_FREE    = 3'd4,
        ST_BAD_ADDR    = 3'd5,
        ST_BAD_SIZE    = 3'd6
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        REG_SMALL_LIMIT = 2'd0,
        REG_BIG_LIMIT   = 2'd1,
        REG_SMALL_BASE  = 2'd2,
        REG_BIG_BASE    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0] small_limit;
        logic [SIZE_W-1:0] big_limit;
        logic [ADDR_W-1:0] small_base;
        logic [ADDR_W-1:0] big_base;
    } t_cfg;

    typedef struct packed {
        t_opcode           opcode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
    } t_item;

    typedef struct packed {
        t_status                status;
        logic [ADDR_W-1:0]      granted_address;
        logic [SMALL_USE_W-1:0] small_in_use;
        logic [BIG_USE_W-1:0]   big_in_use;
    } t_result;

    typedef struct packed {
        logic [SMALL_BLOCKS-1:0] small_map;
        logic [BIG_BLOCKS-1:0]   big_map;
        logic [SMALL_CNT_W-1:0]  small_cnt;
        logic [BIG_CNT_W-1:0]    big_cnt;
    } t_pool_state;

endpackage

`default_nettype wire

// File: rtl/tpba_cfg.sv
`default_nettype none

module tpba_cfg
    import tpba_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.small_limit <= RST_SMALL_LIMIT;
            r_cfg.big_limit   <= RST_BIG_LIMIT;
            r_cfg.small_base  <= RST_SMALL_BASE;
            r_cfg.big_base    <= RST_BIG_BASE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SMALL_LIMIT: r_cfg.small_limit <= pwdata[SIZE_W-1:0];
                REG_BIG_LIMIT:   r_cfg.big_limit   <= pwdata[SIZE_W-1:0];
                REG_SMALL_BASE:  r_cfg.small_base  <= pwdata[ADDR_W-1:0];
                REG_BIG_BASE:    r_cfg.big_base    <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SMALL_LIMIT: prdata = PDATA_W'(r_cfg.small_limit);
            REG_BIG_LIMIT:   prdata = PDATA_W'(r_cfg.big_limit);
            REG_SMALL_BASE:  prdata = PDATA_W'(r_cfg.small_base);
            REG_BIG_BASE:    prdata = PDATA_W'(r_cfg.big_base);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/tpba_engine.sv
`default_nettype none

module tpba_engine
    import tpba_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_fire,
    input  t_cfg        i_cfg,
    input  t_item       i_item,
    output t_result     o_result,
    output t_pool_state o_state
);

    logic [SMALL_BLOCKS-1:0] r_small_map, n_small_map;
    logic [BIG_BLOCKS-1:0]   r_big_map, n_big_map;
    logic [SMALL_CNT_W-1:0]  r_small_cnt, n_small_cnt;
    logic [BIG_CNT_W-1:0]    r_big_cnt, n_big_cnt;

    logic [SMALL_BLOCKS-1:0] w_small_free, w_small_pick;
    logic [BIG_BLOCKS-1:0]   w_big_free, w_big_pick;
    logic [SMALL_IDX_W-1:0]  w_small_idx, w_small_fidx;
    logic [BIG_IDX_W-1:0]    w_big_idx, w_big_fidx;
    logic [ADDR_W-1:0]       w_small_off, w_big_off;
    logic                    w_small_hit, w_big_hit;
    logic                    w_want_big;

    // Isolate the lowest free block, then encode its position.
    assign w_small_free = ~r_small_map;
    assign w_big_free   = ~r_big_map;
    assign w_small_pick = w_small_free & (~w_small_free + 1'b1);
    assign w_big_pick   = w_big_free & (~w_big_free + 1'b1);

    always_comb begin
        w_small_idx = '0;
        for (int i = 0; i < SMALL_BLOCKS; i++) begin
            if (w_small_pick[i]) w_small_idx = w_small_idx | SMALL_IDX_W'(i);
        end
    end

    always_comb begin
        w_big_idx = '0;
        for (int i = 0; i < BIG_BLOCKS; i++) begin
            if (w_big_pick[i]) w_big_idx = w_big_idx | BIG_IDX_W'(i);
        end
    end

    // The offset wraps modulo 2^32, so a pool near the top of the space wraps to zero.
    assign w_small_off  = i_item.free_address - i_cfg.small_base;
    assign w_big_off    = i_item.free_address - i_cfg.big_base;
    assign w_small_hit  = w_small_off < ADDR_W'(SMALL_BLOCKS);
    assign w_big_hit    = w_big_off < ADDR_W'(BIG_BLOCKS);
    assign w_small_fidx = w_small_off[SMALL_IDX_W-1:0];
    assign w_big_fidx   = w_big_off[BIG_IDX_W-1:0];

    always_comb begin
        n_small_map = r_small_map;
        n_big_map   = r_big_map;
        n_small_cnt = r_small_cnt;
        n_big_cnt   = r_big_cnt;
        w_want_big  = 1'b0;
        o_result.status          = ST_HEAP;
        o_result.granted_address = '0;
        if (i_item.opcode == OP_ALLOC) begin
            if (i_item.request_size == '0) begin
                o_result.status = ST_BAD_SIZE;
            end else begin
                if (i_item.request_size <= i_cfg.small_limit) begin
                    if (|w_small_free) begin
                        n_small_map[w_small_idx] = 1'b1;
                        n_small_cnt = r_small_cnt + SMALL_CNT_W'(1);
                        o_result.granted_address = i_cfg.small_base + ADDR_W'(w_small_idx);
                        o_result.status = ST_SMALL_GRANT;
                    end else begin
                        w_want_big = 1'b1;
                    end
                end else if (i_item.request_size <= i_cfg.big_limit) begin
                    w_want_big = 1'b1;
                end
                if (w_want_big && (|w_big_free)) begin
                    n_big_map[w_big_idx] = 1'b1;
                    n_big_cnt = r_big_cnt + BIG_CNT_W'(1);
                    o_result.granted_address = i_cfg.big_base + ADDR_W'(w_big_idx);
                    o_result.status = ST_BIG_GRANT;
                end
            end
        end else begin
            if (w_small_hit) begin
                o_result.status = ST_SMALL_FREE;
                if (r_small_map[w_small_fidx]) begin
                    n_small_map[w_small_fidx] = 1'b0;
                    n_small_cnt = r_small_cnt - SMALL_CNT_W'(1);
                end
            end else if (w_big_hit) begin
                o_result.status = ST_BIG_FREE;
                if (r_big_map[w_big_fidx]) begin
                    n_big_map[w_big_fidx] = 1'b0;
                    n_big_cnt = r_big_cnt - BIG_CNT_W'(1);
                end
            end else begin
                o_result.status = ST_BAD_ADDR;
            end
        end
        o_result.small_in_use = SMALL_USE_W'(n_small_cnt);
        o_result.big_in_use   = BIG_USE_W'(n_big_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_map <= '0;
            r_big_map   <= '0;
            r_small_cnt <= '0;
            r_big_cnt   <= '0;
        end else if (i_fire) begin
            r_small_map <= n_small_map;
            r_big_map   <= n_big_map;
            r_small_cnt <= n_small_cnt;
            r_big_cnt   <= n_big_cnt;
        end
    end

    assign o_state.small_map = r_small_map;
    assign o_state.big_map   = r_big_map;
    assign o_state.small_cnt = r_small_cnt;
    assign o_state.big_cnt   = r_big_cnt;

endmodule

`default_nettype wire

// File: rtl/two_pool_block_allocator_core.sv
// Channel   Direction  Handshake               Payload
// in        to block   i_in_valid/o_in_stall   i_opcode, i_request_size, i_free_address
// out       from block o_out_valid/i_out_stall o_status, o_granted_address, o_*_in_use
// cfg       to block   APB psel/penable/pready paddr, pwdata, prdata
//
// An item is held in the input register and is resolved into the result register
// when the result side is not stalled; one item is taken per cycle while the output does not stall.
// The bitmaps and counts update at the same edge, so back-to-back items see each other.
// A stalled result holds the input register, which then stalls the input channel.
// Synchronous active-low reset frees all blocks and loads the default limits and bases.
`default_nettype none

module two_pool_block_allocator_core
    import tpba_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_opcode,
    input  wire logic [SIZE_W-1:0]      i_request_size,
    input  wire logic [ADDR_W-1:0]      i_free_address,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [STATUS_W-1:0]         o_status,
    output logic [ADDR_W-1:0]           o_granted_address,
    output logic [SMALL_USE_W-1:0]      o_small_in_use,
    output logic [BIG_USE_W-1:0]        o_big_in_use,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic      [PDATA_W-1:0]     prdata,
    output logic                        pready
);

    logic        r_in_valid, n_in_valid;
    t_item       r_in_item;
    logic        r_out_valid, n_out_valid;
    t_result     r_out_res;
    t_result     w_res;
    t_cfg        w_cfg;
    t_pool_state w_state;
    logic        w_out_blocked, w_advance, w_load;

    assign w_out_blocked = r_out_valid && i_out_stall;
    assign w_advance     = r_in_valid && !w_out_blocked;
    assign o_in_stall    = r_in_valid && w_out_blocked;
    assign w_load        = i_in_valid && !o_in_stall;

    tpba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tpba_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_cfg    (w_cfg),
        .i_item   (r_in_item),
        .o_result (w_res),
        .o_state  (w_state)
    );

    always_comb begin
        if (w_load) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_item.opcode       <= t_opcode'(i_opcode);
            r_in_item.request_size <= i_request_size;
            r_in_item.free_address <= i_free_address;
        end
        if (w_advance) begin
            r_out_res <= w_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_res.status;
    assign o_granted_address = r_out_res.granted_address;
    assign o_small_in_use    = r_out_res.small_in_use;
    assign o_big_in_use      = r_out_res.big_in_use;

`ifndef SYNTHESIS
    a_small_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_state.small_map) == int'(w_state.small_cnt))
        else $error("small pool count does not match its bitmap");

    a_big_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_state.big_map) == int'(w_state.big_cnt))
        else $error("big pool count does not match its bitmap");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_SMALL_GRANT && o_status != ST_BIG_GRANT)
        |-> o_granted_address == '0)
        else $error("address reported on a result that is not a grant");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_blocked) |=> r_in_valid)
        else $error("pending item lost while the result side was stalled");
`endif

endmodule

`default_nettype wire

// File: dv/tb_two_pool_block_allocator_core.sv
`default_nettype none

module tb_two_pool_block_allocator_core;
    import tpba_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_opcode = OP_ALLOC;
    logic [SIZE_W-1:0]      i_request_size = '0;
    logic [ADDR_W-1:0]      i_free_address = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [ADDR_W-1:0]      o_granted_address;
    logic [SMALL_USE_W-1:0] o_small_in_use;
    logic [BIG_USE_W-1:0]   o_big_in_use;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    two_pool_block_allocator_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_request_size    (i_request_size),
        .i_free_address    (i_free_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_small_in_use    (o_small_in_use),
        .o_big_in_use      (o_big_in_use),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Pool configuration as the block should hold it.
    logic [SIZE_W-1:0] lim_small = RST_SMALL_LIMIT;
    logic [SIZE_W-1:0] lim_big = RST_BIG_LIMIT;
    logic [ADDR_W-1:0] base_small = RST_SMALL_BASE;
    logic [ADDR_W-1:0] base_big = RST_BIG_BASE;

    // Bitmaps and use counts of both pools.
    logic [SMALL_BLOCKS-1:0] small_taken = '0;
    logic [BIG_BLOCKS-1:0]   big_taken = '0;
    int unsigned             small_used = 0;
    int unsigned             big_used = 0;

    t_item   request_q[$];
    t_result awaited_outcomes[$];
    t_item   cur_request;
    int      issued_cnt = 0;
    int      checked_cnt = 0;
    int      mismatches = 0;
    int      quiet_cycles = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    int unsigned mon_cycle = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Applies one request to the pool state and returns the outcome it must produce.
    task automatic resolve_request(input t_item it, output t_result res);
        logic [ADDR_W-1:0] small_off;
        logic [ADDR_W-1:0] big_off;
        int                slot;
        int                k;
        logic              go_big;
        res.status = ST_HEAP;
        res.granted_address = '0;
        go_big = 1'b0;
        if (it.opcode == OP_ALLOC) begin
            if (it.request_size == '0) begin
                res.status = ST_BAD_SIZE;
            end else begin
                if (it.request_size <= lim_small) begin
                    slot = SMALL_BLOCKS;
                    for (k = SMALL_BLOCKS - 1; k >= 0; k--) begin
                        if (!small_taken[k]) slot = k;
                    end
                    if (slot < SMALL_BLOCKS) begin
                        small_taken[slot] = 1'b1;
                        small_used++;
                        res.granted_address = base_small + ADDR_W'(slot);
                        res.status = ST_SMALL_GRANT;
                    end else begin
                        go_big = 1'b1;
                    end
                end else if (it.request_size <= lim_big) begin
                    go_big = 1'b1;
                end
                // A small request overflows here even when it is above the big limit.
                if (go_big) begin
                    slot = BIG_BLOCKS;
                    for (k = BIG_BLOCKS - 1; k >= 0; k--) begin
                        if (!big_taken[k]) slot = k;
                    end
                    if (slot < BIG_BLOCKS) begin
                        big_taken[slot] = 1'b1;
                        big_used++;
                        res.granted_address = base_big + ADDR_W'(slot);
                        res.status = ST_BIG_GRANT;
                    end
                end
            end
        end else begin
            // Offsets wrap modulo 2^32, and the small pool wins where the pools overlap.
            small_off = it.free_address - base_small;
            big_off = it.free_address - base_big;
            if (small_off < SMALL_BLOCKS) begin
                if (small_taken[small_off]) begin
                    small_taken[small_off] = 1'b0;
                    small_used--;
                end
                res.status = ST_SMALL_FREE;
            end else if (big_off < BIG_BLOCKS) begin
                if (big_taken[big_off]) begin
                    big_taken[big_off] = 1'b0;
                    big_used--;
                end
                res.status = ST_BIG_FREE;
            end else begin
                res.status = ST_BAD_ADDR;
            end
        end
        res.small_in_use = SMALL_USE_W'(small_used);
        res.big_in_use = BIG_USE_W'(big_used);
    endtask

    function automatic logic [SIZE_W-1:0] random_size();
        int unsigned s_lim;
        int unsigned b_lim;
        s_lim = lim_small;
        b_lim = lim_big;
        case ($urandom_range(19))
            0: return '0;
            1, 2, 3, 4, 5, 6, 7, 8: return SIZE_W'($urandom_range(s_lim, 1));
            9, 10, 11, 12, 13: begin
                if (b_lim > s_lim) return SIZE_W'($urandom_range(b_lim, s_lim + 1));
                return SIZE_W'($urandom_range(65535, 1));
            end
            14, 15: begin
                if (b_lim < 65535) return SIZE_W'($urandom_range(65535, b_lim + 1));
                return '1;
            end
            16: return '1;
            17: return SIZE_W'(s_lim);
            18: return SIZE_W'(b_lim);
            default: return SIZE_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        case ($urandom_range(11))
            0, 1, 2, 3, 4: return base_small + ADDR_W'($urandom_range(SMALL_BLOCKS - 1));
            5, 6, 7: return base_big + ADDR_W'($urandom_range(BIG_BLOCKS - 1));
            8: return $urandom_range(1) ? base_small - 1 : base_small + ADDR_W'(SMALL_BLOCKS);
            9: return $urandom_range(1) ? base_big - 1 : base_big + ADDR_W'(BIG_BLOCKS);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_request(input t_opcode op, input logic [SIZE_W-1:0] sz,
                                input logic [ADDR_W-1:0] addr);
        t_item it;
        it.opcode = op;
        it.request_size = sz;
        it.free_address = addr;
        request_q.push_back(it);
    endtask

    // Picks fill-heavy, drain-heavy or balanced runs at random so both pools go full and empty again.
    task automatic queue_random_mix(input int count);
        int left;
        int chunk;
        int alloc_pct;
        left = count;
        while (left > 0) begin
            chunk = $urandom_range(60, 10);
            if (chunk > left) chunk = left;
            case ($urandom_range(3))
                0, 1: alloc_pct = 85;
                2: alloc_pct = 20;
                default: alloc_pct = 50;
            endcase
            repeat (chunk) begin
                push_request(($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE,
                             random_size(), random_address());
            end
            left -= chunk;
        end
    endtask

    task automatic wait_until_drained();
        while (request_q.size() != 0 || issued_cnt != checked_cnt) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SMALL_LIMIT: lim_small = value[SIZE_W-1:0];
            REG_BIG_LIMIT:   lim_big = value[SIZE_W-1:0];
            REG_SMALL_BASE:  base_small = value;
            REG_BIG_BASE:    base_big = value;
            default: ;
        endcase
    endtask

    task automatic program_pools(input logic [SIZE_W-1:0] s_lim, input logic [SIZE_W-1:0] b_lim,
                                 input logic [ADDR_W-1:0] s_base, input logic [ADDR_W-1:0] b_base);
        wait_until_drained();
        write_register(REG_SMALL_LIMIT, PDATA_W'(s_lim));
        write_register(REG_BIG_LIMIT, PDATA_W'(b_lim));
        write_register(REG_SMALL_BASE, s_base);
        write_register(REG_BIG_BASE, b_base);
    endtask

    // Request driver: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin
        t_result outcome;
        logic    nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                resolve_request(cur_request, outcome);
                awaited_outcomes.push_back(outcome);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_q.size() > 0) begin
                    cur_request = request_q.pop_front();
                    issued_cnt++;
                    i_opcode <= cur_request.opcode;
                    i_request_size <= cur_request.request_size;
                    i_free_address <= cur_request.free_address;
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(24, 1);
                        case ($urandom_range(5))
                            0, 1: gap_left = 0;
                            2: gap_left = $urandom_range(20, 8);
                            default: gap_left = $urandom_range(5, 1);
                        endcase
                    end
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // Result monitor with its own stall pattern, which steps through four modes in turn.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                checked_cnt++;
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("result transaction with no request outstanding");
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  o_status, want.status));
                    if (o_granted_address !== want.granted_address)
                        report_mismatch($sformatf("granted_address got %h want %h",
                                                  o_granted_address, want.granted_address));
                    if (o_small_in_use !== want.small_in_use)
                        report_mismatch($sformatf("small_in_use got %0d want %0d",
                                                  o_small_in_use, want.small_in_use));
                    if (o_big_in_use !== want.big_in_use)
                        report_mismatch($sformatf("big_in_use got %0d want %0d",
                                                  o_big_in_use, want.big_in_use));
                end
            end
            mon_cycle++;
            case ((mon_cycle / 97) % 4)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(3) == 0);
                2: i_out_stall <= ($urandom_range(3) != 0);
                default: i_out_stall <= ((mon_cycle % 5) < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Size edges, lowest-free reuse, double frees and decode edges at reset settings.
        push_request(OP_ALLOC, 16'd0, 32'hFFFF_FFFF);
        push_request(OP_ALLOC, 16'd1, 32'd0);
        push_request(OP_ALLOC, 16'd64, 32'd0);
        push_request(OP_ALLOC, 16'd65, 32'd0);
        push_request(OP_ALLOC, 16'd1024, 32'd0);
        push_request(OP_ALLOC, 16'd1025, 32'd0);
        push_request(OP_ALLOC, 16'hFFFF, 32'd0);
        push_request(OP_FREE, 16'hFFFF, 32'd0);
        push_request(OP_FREE, 16'd0, 32'd0);
        push_request(OP_FREE, 16'd0, 32'd257);
        push_request(OP_FREE, 16'd0, 32'd257);
        push_request(OP_FREE, 16'd0, 32'd31);
        push_request(OP_FREE, 16'd0, 32'd32);
        push_request(OP_FREE, 16'd0, 32'd255);
        push_request(OP_FREE, 16'd0, 32'd272);
        push_request(OP_FREE, 16'd0, 32'd271);
        push_request(OP_FREE, 16'hFFFF, 32'hFFFF_FFFF);
        push_request(OP_ALLOC, 16'd64, 32'hFFFF_FFFF);
        push_request(OP_ALLOC, 16'd2, 32'd0);
        push_request(OP_FREE, 16'd0, 32'd256);
        queue_random_mix(130);

        // Small pool wraps through address zero, right below the big pool.
        program_pools(16'd1, 16'hFFFF, 32'hFFFF_FFF0, 32'h0000_0010);
        queue_random_mix(135);

        // Small limit above the big limit, and partly overlapping pools.
        program_pools(16'hFFFF, 16'd1, 32'd100, 32'd120);
        queue_random_mix(135);

        program_pools(16'd16, 16'd2048, 32'hFFFF_FFFF, 32'h7FFF_FFF8);
        queue_random_mix(135);

        program_pools(SIZE_W'($urandom_range(65535, 1)), SIZE_W'($urandom_range(65535, 1)),
                      $urandom, $urandom);
        queue_random_mix(135);

        program_pools(SIZE_W'($urandom_range(2048, 1)), SIZE_W'($urandom_range(65535, 1)),
                      $urandom, $urandom);
        queue_random_mix(135);

        // Big pool starts at the top address and overlaps the bottom of the small pool.
        program_pools(16'd64, 16'd1024, 32'd0, 32'hFFFF_FFFF);
        queue_random_mix(100);

        wait_until_drained();
        if (awaited_outcomes.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      awaited_outcomes.size()));
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/tpba_pkg.sv
rtl/tpba_cfg.sv
rtl/tpba_engine.sv
rtl/two_pool_block_allocator_core.sv
dv/tb_two_pool_block_allocator_core.sv
